@@ hdl/point_lexicographic_sorter_macros.svh @@
// ----------------------------------------------------------------------------
// Point lexicographic sorter: assertion macros
// Shared concurrent-assertion wrappers, clocked on clk and reset on rst.
// ----------------------------------------------------------------------------
`ifndef POINT_LEXICOGRAPHIC_SORTER_MACROS_SVH
`define POINT_LEXICOGRAPHIC_SORTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked at every clock edge outside reset.
`define PLSORT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define PLSORT_ASSERT_IMPL(lbl, ante, cons, msg) \
  `PLSORT_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication checked outside reset.
`define PLSORT_ASSERT_NEXT(lbl, ante, cons, msg) \
  `PLSORT_ASSERT(lbl, (ante) |=> (cons), msg)

`else

`define PLSORT_ASSERT(lbl, prop, msg)
`define PLSORT_ASSERT_IMPL(lbl, ante, cons, msg)
`define PLSORT_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ hdl/plsort_pkg.sv @@
// ----------------------------------------------------------------------------
// Point lexicographic sorter: package
// Order codes and the control bundle broadcast to every sorting cell.
// ----------------------------------------------------------------------------
package plsort_pkg;

  // Sort order codes; any other code sorts like ORDER_X_YDESC.
  localparam logic [1:0] ORDER_XY      = 2'd0;
  localparam logic [1:0] ORDER_YX      = 2'd1;
  localparam logic [1:0] ORDER_X_YDESC = 2'd2;

  // Control broadcast from the top level to every cell of the chain.
  typedef struct packed {
    logic       insert;     // place the broadcast point into the chain
    logic       shift_out;  // move every entry one cell toward the head
    logic [1:0] order_mode; // active sort order
  } cell_ctrl_t;

endpackage

@@ hdl/point_lexicographic_sorter.sv @@
// ----------------------------------------------------------------------------
// Point lexicographic sorter: top level
// Loads a set of 2-D points into a systolic insertion chain and streams them
// back out in lexicographic order.
// ----------------------------------------------------------------------------
// Usage:
//   Points arrive on the s_axis channel, one per transfer; tlast closes the
//   set. Each accepted point is inserted straight into its sorted place,
//   so loading runs at one point per cycle with s_axis_tready held high.
//   Points beyond MAX_POINTS are dropped and the run is flagged in tuser.
//   After the closing transfer, s_axis_tready drops; once the drain state
//   is registered, the chain shifts toward its head and each head point
//   goes through the output register onto m_axis, one point per cycle
//   while m_axis_tready is high; the chain shift is what paces the drain.
//   The final point carries m_axis_tlast. A stalled receiver simply
//   freezes the chain and the output register. Loading of the next set
//   starts as the last point enters the output register.
//   cfg carries order_mode and is always ready; write it only while idle.
//   Reset (rst, synchronous) empties the chain, clears the overflow flag and
//   selects x-then-y ascending order.
// ----------------------------------------------------------------------------
`include "point_lexicographic_sorter_macros.svh"

module point_lexicographic_sorter #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 12
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // cfg_data: order_mode
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [1:0]                             cfg_data,
  // s_axis_tdata: point_x, point_y (low bits first), zero padded
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
  input  logic                                   s_axis_tlast,
  // m_axis_tdata: sorted_x, sorted_y (low bits first), zero padded
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [((2*COORD_BITS+7)/8)*8-1:0]      m_axis_tdata,
  output logic                                   m_axis_tlast,
  // m_axis_tuser: overflowed
  output logic                                   m_axis_tuser
);
  import plsort_pkg::*;

  localparam int DATA_W = ((2*COORD_BITS+7)/8)*8;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);

  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic                  state;
  logic [1:0]            order_mode;
  logic [CNT_W-1:0]      count;
  logic                  overflow_seen;
  logic                  in_xfer;
  logic                  has_room;
  logic                  out_load;
  cell_ctrl_t            ctrl;
  logic [COORD_BITS-1:0] in_x;
  logic [COORD_BITS-1:0] in_y;
  logic [COORD_BITS-1:0] out_x;
  logic [COORD_BITS-1:0] out_y;

  logic [MAX_POINTS-1:0] cell_valid;
  logic [MAX_POINTS-1:0] cell_le;
  logic [COORD_BITS-1:0] cell_x [MAX_POINTS];
  logic [COORD_BITS-1:0] cell_y [MAX_POINTS];

  assign in_x      = s_axis_tdata[COORD_BITS-1:0];
  assign in_y      = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
  assign cfg_ready = 1'b1;

  assign s_axis_tready = (state == ST_LOAD);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign has_room      = (count < CNT_W'(MAX_POINTS));
  assign out_load      = (state == ST_DRAIN) && (!m_axis_tvalid || m_axis_tready);

  assign ctrl.insert     = in_xfer && has_room;
  assign ctrl.shift_out  = out_load;
  assign ctrl.order_mode = order_mode;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      order_mode <= ORDER_XY;
    end else if (cfg_valid && cfg_ready) begin
      order_mode <= cfg_data;
    end
  end

  // Load/drain sequencing, fill count and overflow tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      count         <= '0;
      overflow_seen <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (in_xfer) begin
            if (has_room) begin
              count <= count + CNT_W'(1);
            end else begin
              overflow_seen <= 1'b1;
            end
            if (s_axis_tlast) begin
              state <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (out_load) begin
            count <= count - CNT_W'(1);
            if (count == CNT_W'(1)) begin
              state         <= ST_LOAD;
              overflow_seen <= 1'b0;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  // Output register fed from the head cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x        <= cell_x[0];
      out_y        <= cell_y[0];
      m_axis_tlast <= (count == CNT_W'(1));
      m_axis_tuser <= overflow_seen;
    end
  end

  assign m_axis_tdata = DATA_W'({out_y, out_x});

  // Insertion chain; the head cell has no predecessor, the tail no successor.
  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    logic                  p_valid;
    logic [COORD_BITS-1:0] p_x;
    logic [COORD_BITS-1:0] p_y;
    logic                  p_le;
    logic                  n_valid;
    logic [COORD_BITS-1:0] n_x;
    logic [COORD_BITS-1:0] n_y;

    if (i == 0) begin : g_head
      assign p_valid = 1'b0;
      assign p_x     = '0;
      assign p_y     = '0;
      assign p_le    = 1'b1;
    end else begin : g_body
      assign p_valid = cell_valid[i-1];
      assign p_x     = cell_x[i-1];
      assign p_y     = cell_y[i-1];
      assign p_le    = cell_le[i-1];
    end

    if (i == MAX_POINTS - 1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_x     = '0;
      assign n_y     = '0;
    end else begin : g_inner
      assign n_valid = cell_valid[i+1];
      assign n_x     = cell_x[i+1];
      assign n_y     = cell_y[i+1];
    end

    plsort_cell #(
      .COORD_BITS (COORD_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .new_x      (in_x),
      .new_y      (in_y),
      .prev_valid (p_valid),
      .prev_x     (p_x),
      .prev_y     (p_y),
      .prev_le    (p_le),
      .next_valid (n_valid),
      .next_x     (n_x),
      .next_y     (n_y),
      .valid      (cell_valid[i]),
      .x          (cell_x[i]),
      .y          (cell_y[i]),
      .le         (cell_le[i])
    );
  end

  // Occupied cells always match the fill count.
  `PLSORT_ASSERT(a_count_matches_cells, CNT_W'($countones(cell_valid)) == count, "bad occupancy")
  `PLSORT_ASSERT(a_count_in_range, count <= CNT_W'(MAX_POINTS), "fill count beyond capacity")
  `PLSORT_ASSERT_IMPL(a_drain_nonempty, state == ST_DRAIN, count != '0, "empty chain drain")
  `PLSORT_ASSERT_NEXT(a_set_end_drains, in_xfer && s_axis_tlast, state == ST_DRAIN, "no drain")

endmodule

@@ hdl/plsort_cell.sv @@
// ----------------------------------------------------------------------------
// Point lexicographic sorter: insertion cell
// Holds one point of the sorted chain and compares it with the broadcast point.
// ----------------------------------------------------------------------------
module plsort_cell #(
  parameter int COORD_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  plsort_pkg::cell_ctrl_t ctrl,
  input  logic [COORD_BITS-1:0]  new_x,
  input  logic [COORD_BITS-1:0]  new_y,
  input  logic                   prev_valid,
  input  logic [COORD_BITS-1:0]  prev_x,
  input  logic [COORD_BITS-1:0]  prev_y,
  input  logic                   prev_le,
  input  logic                   next_valid,
  input  logic [COORD_BITS-1:0]  next_x,
  input  logic [COORD_BITS-1:0]  next_y,
  output logic                   valid,
  output logic [COORD_BITS-1:0]  x,
  output logic [COORD_BITS-1:0]  y,
  output logic                   le
);
  import plsort_pkg::*;

  localparam int KEY_W = 2 * COORD_BITS;

  logic [KEY_W-1:0] own_key;
  logic [KEY_W-1:0] new_key;

  // Lexicographic key; a descending coordinate is stored inverted.
  function automatic logic [KEY_W-1:0] key_of(input logic [1:0] mode,
                                               input logic [COORD_BITS-1:0] kx,
                                               input logic [COORD_BITS-1:0] ky);
    logic [KEY_W-1:0] k;
    case (mode)
      ORDER_XY: k = {kx, ky};
      ORDER_YX: k = {ky, kx};
      default:  k = {kx, ~ky};
    endcase
    return k;
  endfunction

  assign own_key = key_of(ctrl.order_mode, x, y);
  assign new_key = key_of(ctrl.order_mode, new_x, new_y);

  // The held point stays ahead of the new one when its key is not larger.
  assign le = valid && (own_key <= new_key);

  // Keep, take the new point, or take the predecessor's point; or shift out.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift_out) begin
      valid <= next_valid;
      x     <= next_x;
      y     <= next_y;
    end else if (ctrl.insert && !le) begin
      if (prev_le) begin
        valid <= 1'b1;
        x     <= new_x;
        y     <= new_y;
      end else begin
        valid <= prev_valid;
        x     <= prev_x;
        y     <= prev_y;
      end
    end
  end

endmodule
